>>> design/dlsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dlsc_pkg;

    localparam int A_W        = 25;
    localparam int B_W        = 17;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    typedef logic [A_W-1:0]        t_shift_a;
    typedef logic [B_W-1:0]        t_shift_b;
    typedef logic [BYTE_W-1:0]     t_byte;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx REG_SEED_A = t_cfg_idx'(0);
    localparam t_cfg_idx REG_SEED_B = t_cfg_idx'(1);

    localparam t_shift_a SEED_A_RESET = t_shift_a'(158);
    localparam t_shift_b SEED_B_RESET = t_shift_b'(105);

    // Bit 3 is forced on every load so that neither register can start at zero.
    localparam t_shift_a LOAD_MASK_A = t_shift_a'(8);
    localparam t_shift_b LOAD_MASK_B = t_shift_b'(8);

    typedef struct packed {
        logic      en;
        t_cfg_idx  index;
        t_cfg_data data;
    } t_cfg_wr;

    typedef struct packed {
        logic advance;
        logic restart;
    } t_step_req;

    // Eight right shifts of the 25-bit register, feedback from bits 14, 4, 3 and 0.
    function automatic t_shift_a step_a(input t_shift_a r);
        t_shift_a v;
        logic     fb;
        v = r;
        for (int k = 0; k < BYTE_W; k++) begin
            fb = v[14] ^ v[4] ^ v[3] ^ v[0];
            v  = {fb, v[A_W-1:1]};
        end
        return v;
    endfunction

    // Eight right shifts of the 17-bit register, feedback from bits 14 and 0.
    function automatic t_shift_b step_b(input t_shift_b r);
        t_shift_b v;
        logic     fb;
        v = r;
        for (int k = 0; k < BYTE_W; k++) begin
            fb = v[14] ^ v[0];
            v  = {fb, v[B_W-1:1]};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/dlsc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dlsc_in_if;
    logic                 valid;
    logic                 ready;
    dlsc_pkg::t_byte      data_byte;
    logic                 restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface dlsc_out_if;
    logic                 valid;
    logic                 ready;
    dlsc_pkg::t_byte      out_byte;
    dlsc_pkg::t_byte      key_byte;

    modport source (output valid, output out_byte, output key_byte, input ready);
    modport sink   (input valid, input out_byte, input key_byte, output ready);
endinterface

interface dlsc_cfg_if;
    logic                 valid;
    logic                 ready;
    dlsc_pkg::t_cfg_idx   index;
    dlsc_pkg::t_cfg_data  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/dlsc_keygen.sv
`timescale 1ns / 1ps
`default_nettype none

module dlsc_keygen (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dlsc_pkg::t_cfg_wr   i_cfg_wr,
    input  wire dlsc_pkg::t_step_req i_step,
    output dlsc_pkg::t_byte          o_key
);
    import dlsc_pkg::*;

    t_shift_a r_seed_a;
    t_shift_b r_seed_b;
    t_shift_a r_shift_a;
    t_shift_b r_shift_b;
    logic     r_carry;

    t_shift_a         src_a;
    t_shift_b         src_b;
    logic             src_carry;
    t_shift_a         n_shift_a;
    t_shift_b         n_shift_b;
    logic [BYTE_W:0]  sum;
    logic             n_carry;

    always_comb begin
        if (i_step.restart) begin
            src_a     = r_seed_a | LOAD_MASK_A;
            src_b     = r_seed_b | LOAD_MASK_B;
            src_carry = 1'b0;
        end else begin
            src_a     = r_shift_a;
            src_b     = r_shift_b;
            src_carry = r_carry;
        end
        n_shift_a = step_a(src_a);
        n_shift_b = step_b(src_b);
        sum = {1'b0, n_shift_a[A_W-1 -: BYTE_W]} + {1'b0, n_shift_b[B_W-1 -: BYTE_W]}
            + {{BYTE_W{1'b0}}, src_carry};
        n_carry = sum[BYTE_W];
        o_key   = sum[BYTE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_a  <= SEED_A_RESET;
            r_seed_b  <= SEED_B_RESET;
            r_shift_a <= SEED_A_RESET | LOAD_MASK_A;
            r_shift_b <= SEED_B_RESET | LOAD_MASK_B;
            r_carry   <= 1'b0;
        end else begin
            if (i_cfg_wr.en) begin
                unique case (i_cfg_wr.index)
                    REG_SEED_A: r_seed_a <= i_cfg_wr.data[A_W-1:0];
                    REG_SEED_B: r_seed_b <= i_cfg_wr.data[B_W-1:0];
                    default: ;
                endcase
            end
            if (i_step.advance) begin
                r_shift_a <= n_shift_a;
                r_shift_b <= n_shift_b;
                r_carry   <= n_carry;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/dual_lfsr_stream_cipher_unit.sv
// Channel  Dir  Payload                  Transfer when
// i_in     in   data_byte[7:0], restart  i_in.valid && i_in.ready
// o_out    out  out_byte[7:0], key_byte  o_out.valid && o_out.ready
// i_cfg    in   index[1:0], data[24:0]   i_cfg.valid && i_cfg.ready (always ready)
//
// One byte per cycle sustained unless o_out stalls; bytes pass from the input register to the output register.
// Both LFSR steps, the carry add and the XOR run combinationally from the input register.
// Reset is synchronous; it restores both seeds and loads the shift registers from them.
// While the output is stalled the input register fills, then i_in.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module dual_lfsr_stream_cipher_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dlsc_in_if.sink   i_in,
    dlsc_out_if.source o_out,
    dlsc_cfg_if.sink  i_cfg
);
    import dlsc_pkg::*;

    logic      r_in_valid;
    t_byte     r_in_data;
    logic      r_in_restart;
    logic      r_out_valid;
    t_byte     r_out_byte;
    t_byte     r_key_byte;

    logic      advance;
    t_byte     key;
    t_cfg_wr   cfg_wr;
    t_step_req step;

    assign advance = r_in_valid && (!r_out_valid || o_out.ready);

    assign cfg_wr.en    = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;
    assign i_cfg.ready  = 1'b1;

    assign step.advance = advance;
    assign step.restart = r_in_restart;

    dlsc_keygen u_keygen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (cfg_wr),
        .i_step   (step),
        .o_key    (key)
    );

    assign i_in.ready     = !r_in_valid || advance;
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.key_byte = r_key_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_data    <= i_in.data_byte;
            r_in_restart <= i_in.restart;
        end
        if (advance) begin
            r_out_byte <= r_in_data ^ key;
            r_key_byte <= key;
        end
    end

endmodule

`default_nettype wire

>>> design/dlsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dlsc_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            i_in_ready,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire dlsc_pkg::t_byte i_out_byte,
    input wire dlsc_pkg::t_byte i_key_byte,
    input wire logic            i_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Output valid dropped without a transfer.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_key_byte))
        else $error("Output payload changed while stalled.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready |=> i_out_valid)
        else $error("Accepted byte did not reach the output register.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready && i_cfg_ready)
        else $error("Input not ready while the output register is empty.");

endmodule

bind dual_lfsr_stream_cipher_unit dlsc_checker u_dlsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_key_byte  (o_out.key_byte),
    .i_cfg_ready (i_cfg.ready)
);

`default_nettype wire
